// ===== hdl/mbus_rhr_pkg.sv =====
// Shared types, constants and the CRC-16 byte function of the Modbus
// read-holding-registers slave. No dependencies; compiled first.
package mbus_rhr_pkg;

  localparam int REG_DEPTH    = 256;
  localparam int REG_AW       = $clog2(REG_DEPTH);
  localparam int MAX_QUANTITY = 125;
  localparam int MIN_FRAME    = 8;
  localparam int HEAD_BYTES   = 6;

  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [7:0]  SLAVE_ID_RST = 8'h01;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  // Receive count saturates as soon as it proves the minimum frame length.
  localparam int         RX_CNT_W   = 4;
  localparam logic [3:0] RX_CNT_SAT = 4'(MIN_FRAME);

  localparam logic [1:0] CMD_RECV  = 2'd0;
  localparam logic [1:0] CMD_PULL  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] FS_NONE   = 2'd0;
  localparam logic [1:0] FS_ACCEPT = 2'd1;
  localparam logic [1:0] FS_IGNORE = 2'd2;

  // Which reply byte a pull produces.
  typedef enum logic [2:0] {
    KIND_ID,
    KIND_FUNC,
    KIND_COUNT,
    KIND_REG_HI,
    KIND_REG_LO,
    KIND_CRC_LO,
    KIND_CRC_HI
  } tx_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  reg_index;
    logic [15:0] reg_value;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [1:0] frame_status;
  } rsp_t;

  // Descriptor handed from the front stage to the reply stage.
  typedef struct packed {
    logic       tx_valid;
    tx_kind_e   kind;
    logic       last;
    logic [7:0] count_byte;
    logic [1:0] frame_status;
    logic       arm;
  } desc_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [REG_AW-1:0] raddr;
  } ram_req_t;

  // One byte of CRC-16/Modbus, reflected polynomial.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/mbus_rhr_if.sv =====
// Handshake channels of the Modbus read-holding-registers slave:
// request items, result items and the slave address write port.
// Depends on nothing.
interface mbus_rhr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  rx_byte;
  logic        frame_end;
  logic [7:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, command, rx_byte, frame_end, reg_index, reg_value,
                  input ready);
  modport sink (input valid, command, rx_byte, frame_end, reg_index, reg_value,
                output ready);
endinterface

interface mbus_rhr_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic [1:0] frame_status;

  modport source (output valid, tx_valid, tx_byte, tx_last, frame_status, input ready);
  modport sink (input valid, tx_valid, tx_byte, tx_last, frame_status, output ready);
endinterface

interface mbus_rhr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_id;

  modport source (output valid, slave_id, input ready);
  modport sink (input valid, slave_id, output ready);
endinterface

// ===== hdl/mbus_rhr_regs.sv =====
// Holding register table: 16-bit entries, one write and one registered read
// per cycle. Entries never written read as zero. Depends on mbus_rhr_pkg.
module mbus_rhr_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mbus_rhr_pkg::ram_req_t ram_i,
  output logic [15:0]            rd_data_o
);
  import mbus_rhr_pkg::*;

  logic [15:0]          mem_q [REG_DEPTH];
  logic [REG_DEPTH-1:0] written_q;
  logic [15:0]          rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ram_i.we) begin
      mem_q[ram_i.waddr] <= ram_i.wdata;
    end
    if (ram_i.re) begin
      rdata_q <= mem_q[ram_i.raddr];
    end
  end

  // Written flags stand in for clearing the table at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (ram_i.we) begin
        written_q[ram_i.waddr] <= 1'b1;
      end
      if (ram_i.re) begin
        rvalid_q <= written_q[ram_i.raddr];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : 16'h0000;

endmodule

// ===== hdl/mbus_rhr_rx.sv =====
// Front stage: frame reception with running CRC and checks, reply
// sequencing, and table access requests. Depends on mbus_rhr_pkg.
module mbus_rhr_rx (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  mbus_rhr_pkg::req_t     req_i,
  input  logic [7:0]             slave_id_i,
  input  logic                   desc_take_i,
  output logic                   desc_valid_o,
  output mbus_rhr_pkg::desc_t    desc_o,
  output mbus_rhr_pkg::ram_req_t ram_o
);
  import mbus_rhr_pkg::*;

  logic [HEAD_BYTES-1:0][7:0] head_q, head_d;
  logic [RX_CNT_W-1:0]        cnt_q, cnt_d, cnt_nx;
  logic [15:0]                rx_crc_q, rx_crc_d, crc_nx;
  logic                       pend_q, pend_d;
  logic [7:0]                 pos_q, pos_d;
  logic [REG_AW-1:0]          start_q, start_d;
  logic [6:0]                 qty_q, qty_d;
  logic                       desc_valid_q, desc_valid_d;
  desc_t                      desc_q, desc_d;

  logic        accept;
  logic [15:0] start16, qty16;
  logic        frame_ok;
  logic [7:0]  data_end, off;

  assign req_ready_o = !desc_valid_q || desc_take_i;
  assign accept      = req_valid_i && req_ready_o;

  assign start16  = {head_q[2], head_q[3]};
  assign qty16    = {head_q[4], head_q[5]};
  assign crc_nx   = crc16_byte(rx_crc_q, req_i.rx_byte);
  assign cnt_nx   = (cnt_q == RX_CNT_SAT) ? cnt_q : cnt_q + 1'b1;
  assign data_end = 8'd3 + {qty_q, 1'b0};
  assign off      = pos_q - 8'd3;

  // Once the count reaches the minimum length, the six head bytes are all
  // from earlier items, so the stored copies are complete.
  assign frame_ok = (crc_nx == 16'h0000) && (cnt_nx >= RX_CNT_SAT) &&
                    (head_q[0] == slave_id_i) && (head_q[1] == FUNC_READ) &&
                    (qty16 != 16'h0000) && (32'(qty16) <= MAX_QUANTITY) &&
                    ((32'(start16) + 32'(qty16)) <= REG_DEPTH);

  always_comb begin
    head_d       = head_q;
    cnt_d        = cnt_q;
    rx_crc_d     = rx_crc_q;
    pend_d       = pend_q;
    pos_d        = pos_q;
    start_d      = start_q;
    qty_d        = qty_q;
    desc_d       = desc_q;
    desc_valid_d = desc_valid_q;
    ram_o        = '0;

    if (accept) begin
      desc_valid_d = 1'b1;
      desc_d       = '0;
      unique case (req_i.command)
        CMD_RECV: begin
          rx_crc_d = crc_nx;
          cnt_d    = cnt_nx;
          if (cnt_q < RX_CNT_W'(HEAD_BYTES)) begin
            head_d[cnt_q[2:0]] = req_i.rx_byte;
          end
          if (req_i.frame_end) begin
            head_d   = '0;
            cnt_d    = '0;
            rx_crc_d = CRC_INIT;
            if (frame_ok) begin
              desc_d.frame_status = FS_ACCEPT;
              desc_d.arm          = 1'b1;
              pend_d              = 1'b1;
              pos_d               = 8'd0;
              start_d             = start16[REG_AW-1:0];
              qty_d               = qty16[6:0];
            end else begin
              desc_d.frame_status = FS_IGNORE;
            end
          end
        end
        CMD_PULL: begin
          if (pend_q) begin
            desc_d.tx_valid   = 1'b1;
            desc_d.count_byte = {qty_q, 1'b0};
            pos_d             = pos_q + 8'd1;
            if (pos_q == 8'd0) begin
              desc_d.kind = KIND_ID;
            end else if (pos_q == 8'd1) begin
              desc_d.kind = KIND_FUNC;
            end else if (pos_q == 8'd2) begin
              desc_d.kind = KIND_COUNT;
            end else if (pos_q < data_end) begin
              desc_d.kind = off[0] ? KIND_REG_LO : KIND_REG_HI;
              ram_o.re    = 1'b1;
              ram_o.raddr = REG_AW'(32'(start_q) + 32'(off[7:1]));
            end else if (pos_q == data_end) begin
              desc_d.kind = KIND_CRC_LO;
            end else begin
              desc_d.kind = KIND_CRC_HI;
              desc_d.last = 1'b1;
              pend_d      = 1'b0;
              pos_d       = 8'd0;
            end
          end
        end
        CMD_WRITE: begin
          if (32'(req_i.reg_index) < REG_DEPTH) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = req_i.reg_index[REG_AW-1:0];
            ram_o.wdata = req_i.reg_value;
          end
        end
        default: begin
        end
      endcase
    end else if (desc_take_i) begin
      desc_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      cnt_q        <= '0;
      rx_crc_q     <= CRC_INIT;
      pend_q       <= 1'b0;
      pos_q        <= '0;
      start_q      <= '0;
      qty_q        <= '0;
      desc_valid_q <= 1'b0;
    end else begin
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      rx_crc_q     <= rx_crc_d;
      pend_q       <= pend_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
      qty_q        <= qty_d;
      desc_valid_q <= desc_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

endmodule

// ===== hdl/mbus_rhr_tx.sv =====
// Reply stage: builds the reply byte from the front-stage order and the
// table read data, keeps the reply CRC, and holds the output register.
// Depends on mbus_rhr_pkg.
module mbus_rhr_tx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                desc_valid_i,
  input  mbus_rhr_pkg::desc_t desc_i,
  output logic                desc_take_o,
  input  logic [15:0]         rd_data_i,
  input  logic [7:0]          slave_id_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output mbus_rhr_pkg::rsp_t  rsp_o
);
  import mbus_rhr_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  rsp_t        rsp_q;
  logic [7:0]  byte_val;
  logic        crc_en;
  rsp_t        rsp_d;

  assign desc_take_o = desc_valid_i && (!out_valid_q || rsp_ready_i);

  always_comb begin
    byte_val = 8'h00;
    crc_en   = 1'b0;
    unique case (desc_i.kind)
      KIND_ID: begin
        byte_val = slave_id_i;
        crc_en   = 1'b1;
      end
      KIND_FUNC: begin
        byte_val = FUNC_READ;
        crc_en   = 1'b1;
      end
      KIND_COUNT: begin
        byte_val = desc_i.count_byte;
        crc_en   = 1'b1;
      end
      KIND_REG_HI: begin
        byte_val = rd_data_i[15:8];
        crc_en   = 1'b1;
      end
      KIND_REG_LO: begin
        byte_val = rd_data_i[7:0];
        crc_en   = 1'b1;
      end
      KIND_CRC_LO: byte_val = crc_q[7:0];
      KIND_CRC_HI: byte_val = crc_q[15:8];
      default: byte_val = 8'h00;
    endcase
  end

  always_comb begin
    crc_d = crc_q;
    if (desc_take_o) begin
      if (desc_i.arm) begin
        crc_d = CRC_INIT;
      end else if (desc_i.tx_valid && crc_en) begin
        crc_d = crc16_byte(crc_q, byte_val);
      end
    end
  end

  always_comb begin
    rsp_d.tx_valid     = desc_i.tx_valid;
    rsp_d.tx_byte      = desc_i.tx_valid ? byte_val : 8'h00;
    rsp_d.tx_last      = desc_i.tx_valid && desc_i.last;
    rsp_d.frame_status = desc_i.frame_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      if (desc_take_o) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_take_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== hdl/modbus_read_holding_registers_slave_core.sv =====
// Modbus RTU slave for function 03 (read holding registers), top level.
// Depends on mbus_rhr_pkg, the channel interfaces, mbus_rhr_rx, mbus_rhr_regs
// and mbus_rhr_tx.
//
// Every item (request byte, reply pull or host register write) yields exactly
// one result: the front stage registers the item's effect and issues the
// table read, and the reply stage combines the registered read data into the
// output register. With the result side ready the block sustains one item
// per cycle. The table reads as zero after reset through per-entry written
// flags, so there is no clearing pass and items are taken right after reset.
// The slave address port is always ready and is meant to be written only
// while no item is in flight.
module modbus_read_holding_registers_slave_core (
  input logic            clk_i,
  input logic            rst_ni,
  mbus_rhr_req_if.sink   req_if,
  mbus_rhr_rsp_if.source rsp_if,
  mbus_rhr_cfg_if.sink   cfg_if
);
  import mbus_rhr_pkg::*;

  logic [7:0]  slave_id_q;
  req_t        req;
  rsp_t        rsp;
  desc_t       desc;
  logic        desc_valid;
  logic        desc_take;
  ram_req_t    ram_req;
  logic [15:0] rd_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q <= SLAVE_ID_RST;
    end else if (cfg_if.valid) begin
      slave_id_q <= cfg_if.slave_id;
    end
  end

  assign req.command   = req_if.command;
  assign req.rx_byte   = req_if.rx_byte;
  assign req.frame_end = req_if.frame_end;
  assign req.reg_index = req_if.reg_index;
  assign req.reg_value = req_if.reg_value;

  mbus_rhr_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_o  (req_if.ready),
    .req_i        (req),
    .slave_id_i   (slave_id_q),
    .desc_take_i  (desc_take),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .ram_o        (ram_req)
  );

  mbus_rhr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ram_i     (ram_req),
    .rd_data_o (rd_data)
  );

  mbus_rhr_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_take_o  (desc_take),
    .rd_data_i    (rd_data),
    .slave_id_i   (slave_id_q),
    .rsp_valid_o  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_o        (rsp)
  );

  assign rsp_if.tx_valid     = rsp.tx_valid;
  assign rsp_if.tx_byte      = rsp.tx_byte;
  assign rsp_if.tx_last      = rsp.tx_last;
  assign rsp_if.frame_status = rsp.frame_status;

endmodule

// ===== dv/tb_modbus_read_holding_registers_slave_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the Modbus function-03 slave core: directed and random
// request frames, reply pulls and table writes, predicted in order and compared per item.
// Depends on mbus_rhr_pkg, the channel interfaces and the slave core.
module tb_modbus_read_holding_registers_slave_core;
  import mbus_rhr_pkg::*;

  localparam logic [1:0] CMD_UNUSED        = 2'd3;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam int         PHASE_ITEMS       = 260;
  localparam int         CYCLE_LIMIT       = 600000;

  logic clk_i;
  logic rst_ni;

  mbus_rhr_req_if req_ch ();
  mbus_rhr_rsp_if rsp_ch ();
  mbus_rhr_cfg_if cfg_ch ();

  modbus_read_holding_registers_slave_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_ch),
    .rsp_if (rsp_ch),
    .cfg_if (cfg_ch)
  );

  // Predicted state of the slave.
  logic [15:0] table_m [REG_DEPTH];
  logic [7:0]  head_m [HEAD_BYTES];
  int unsigned rx_len;
  logic [15:0] rx_crc_m;
  bit          reply_armed;
  int unsigned reply_pos;
  int unsigned reply_start;
  int unsigned reply_qty;
  logic [15:0] reply_crc_m;
  logic [7:0]  slave_id_m;

  req_t        pending_items [$];
  rsp_t        expected_replies [$];
  logic [7:0]  frame_buf [$];
  logic [7:0]  id_setting;
  bit          idle_en;
  bit          req_fire;
  int          gap_left;
  int          stall_left;
  int unsigned n_queued, n_taken, n_checked, n_accepted, n_ignored, n_errors;
  int unsigned cycle_count;

  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic clear_receiver();
    foreach (head_m[i]) head_m[i] = 8'h00;
    rx_len   = 0;
    rx_crc_m = CRC_INIT;
  endtask

  task automatic predict_item(input req_t it, output rsp_t res);
    int unsigned start_idx, qty, data_end, ridx;
    logic [7:0]  b;
    logic [15:0] v;
    bit          ok;
    res = '0;
    case (it.command)
      CMD_RECV: begin
        rx_crc_m = crc_next(rx_crc_m, it.rx_byte);
        if (rx_len < HEAD_BYTES) head_m[rx_len] = it.rx_byte;
        if (rx_len < 255) rx_len++;
        if (it.frame_end) begin
          start_idx = {head_m[2], head_m[3]};
          qty       = {head_m[4], head_m[5]};
          ok = rx_crc_m == 16'h0000 && rx_len >= MIN_FRAME && head_m[0] == slave_id_m &&
               head_m[1] == FUNC_READ && qty >= 1 && qty <= MAX_QUANTITY &&
               start_idx + qty <= REG_DEPTH;
          clear_receiver();
          if (ok) begin
            reply_armed = 1'b1;
            reply_pos   = 0;
            reply_start = start_idx;
            reply_qty   = qty;
            reply_crc_m = CRC_INIT;
            res.frame_status = FS_ACCEPT;
            n_accepted++;
          end else begin
            res.frame_status = FS_IGNORE;
            n_ignored++;
          end
        end
      end
      CMD_PULL: begin
        if (reply_armed) begin
          data_end = 3 + 2 * reply_qty;
          if (reply_pos == 0) begin
            b = slave_id_m;
          end else if (reply_pos == 1) begin
            b = FUNC_READ;
          end else if (reply_pos == 2) begin
            b = 8'(2 * reply_qty);
          end else if (reply_pos < data_end) begin
            ridx = reply_start + (reply_pos - 3) / 2;
            v = (ridx < REG_DEPTH) ? table_m[ridx] : 16'h0000;
            b = ((reply_pos - 3) % 2 != 0) ? v[7:0] : v[15:8];
          end else if (reply_pos == data_end) begin
            b = reply_crc_m[7:0];
          end else begin
            b = reply_crc_m[15:8];
            res.tx_last = 1'b1;
          end
          if (reply_pos < data_end) reply_crc_m = crc_next(reply_crc_m, b);
          if (res.tx_last) begin
            reply_armed = 1'b0;
            reply_pos   = 0;
          end else begin
            reply_pos++;
          end
          res.tx_valid = 1'b1;
          res.tx_byte  = b;
        end
      end
      CMD_WRITE: begin
        if (it.reg_index < REG_DEPTH) table_m[it.reg_index] = it.reg_value;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t mismatch: %s expected 0x%0h got 0x%0h", $time, what, want, got);
  endtask

  // Fields a command does not use are randomized as well.
  function automatic req_t random_item();
    req_t it;
    it.command   = 2'($urandom_range(0, 3));
    it.rx_byte   = 8'($urandom);
    it.frame_end = ($urandom_range(0, 3) == 0);
    it.reg_index = 8'($urandom);
    it.reg_value = 16'($urandom);
    return it;
  endfunction

  task automatic queue_item(input req_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    req_t it;
    it = random_item();
    it.command   = CMD_RECV;
    it.rx_byte   = b;
    it.frame_end = last;
    queue_item(it);
  endtask

  task automatic push_pulls(input int n);
    req_t it;
    repeat (n) begin
      it = random_item();
      it.command = CMD_PULL;
      queue_item(it);
    end
  endtask

  task automatic push_write(input logic [7:0] idx, input logic [15:0] val);
    req_t it;
    it = random_item();
    it.command   = CMD_WRITE;
    it.reg_index = idx;
    it.reg_value = val;
    queue_item(it);
  endtask

  task automatic build_read(input logic [7:0] addr, input logic [7:0] func,
                            input logic [15:0] start, input logic [15:0] qty, input int extra);
    frame_buf.delete();
    frame_buf.push_back(addr);
    frame_buf.push_back(func);
    frame_buf.push_back(start[15:8]);
    frame_buf.push_back(start[7:0]);
    frame_buf.push_back(qty[15:8]);
    frame_buf.push_back(qty[7:0]);
    repeat (extra) frame_buf.push_back(8'($urandom));
  endtask

  task automatic push_frame(input bit add_crc, input bit corrupt);
    logic [15:0] c;
    int          k;
    if (add_crc) begin
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc_next(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
    end
    if (corrupt) begin
      k = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[k] = frame_buf[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // A good request, then the reply pulled in full, in part or past its end.
  task automatic read_transaction(input int unsigned start, input int unsigned qty,
                                  input int extra);
    int reply_len, mode;
    build_read(id_setting, FUNC_READ, 16'(start), 16'(qty), extra);
    push_frame(1'b1, 1'b0);
    reply_len = 5 + 2 * qty;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      for (int i = 0; i < reply_len; i++) begin
        if ($urandom_range(0, 19) == 0) push_write(8'($urandom), 16'($urandom));
        push_pulls(1);
      end
    end else if (mode < 8) begin
      push_pulls($urandom_range(1, reply_len - 1));
    end else begin
      push_pulls(reply_len + $urandom_range(1, 3));
    end
  endtask

  task automatic broken_frame();
    int unsigned qty, start;
    logic [7:0]  f;
    case ($urandom_range(0, 8))
      0: begin
        build_read(id_setting, FUNC_READ, 16'($urandom_range(0, 200)), 16'($urandom_range(1, 8)),
                   $urandom_range(0, 1));
        push_frame(1'b1, 1'b1);
      end
      1: begin
        build_read(id_setting ^ 8'(1 << $urandom_range(0, 7)), FUNC_READ, 16'd0, 16'd2, 0);
        push_frame(1'b1, 1'b0);
      end
      2: begin
        build_read(id_setting, FUNC_WRITE_SINGLE, 16'($urandom), 16'($urandom), 0);
        push_frame(1'b1, 1'b0);
      end
      3: begin
        f = 8'($urandom);
        if (f == FUNC_READ) f = 8'h04;
        build_read(id_setting, f, 16'd0, 16'd1, 0);
        push_frame(1'b1, 1'b0);
      end
      4: begin
        build_read(id_setting, FUNC_READ, 16'($urandom_range(0, 255)), 16'd0, 0);
        push_frame(1'b1, 1'b0);
      end
      5: begin
        build_read(id_setting, FUNC_READ, 16'd0, 16'($urandom_range(MAX_QUANTITY + 1, 65535)), 0);
        push_frame(1'b1, 1'b0);
      end
      6: begin
        qty   = $urandom_range(1, MAX_QUANTITY);
        start = $urandom_range(REG_DEPTH + 1 - qty, 65535);
        build_read(id_setting, FUNC_READ, 16'(start), 16'(qty), 0);
        push_frame(1'b1, 1'b0);
      end
      7: begin
        // Too short, even though the checksum closes.
        build_read(id_setting, FUNC_READ, 16'd0, 16'd1, 0);
        frame_buf = frame_buf[0:$urandom_range(0, 4)];
        if ($urandom_range(0, 3) == 0) frame_buf.delete();
        push_frame(1'b1, 1'b0);
      end
      default: begin
        frame_buf.delete();
        repeat ($urandom_range(1, 12)) frame_buf.push_back(8'($urandom));
        push_frame(1'b0, 1'b0);
      end
    endcase
    if ($urandom_range(0, 1) == 0) push_pulls($urandom_range(1, 4));
  endtask

  task automatic random_transaction();
    int unsigned r, qty;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      qty = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_QUANTITY) : $urandom_range(1, 8);
      read_transaction($urandom_range(0, REG_DEPTH - qty), qty,
                       ($urandom_range(0, 6) == 0) ? $urandom_range(1, 4) : 0);
    end else if (r < 57) begin
      repeat ($urandom_range(1, 4)) push_write(8'($urandom), 16'($urandom));
    end else if (r < 82) begin
      broken_frame();
    end else if (r < 92) begin
      repeat ($urandom_range(1, 6)) queue_item(random_item());
    end else begin
      push_pulls($urandom_range(1, 5));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (n_taken != n_queued || expected_replies.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_slave_id(input logic [7:0] id);
    @(negedge clk_i);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.slave_id <= id;
    do @(posedge clk_i); while (!cfg_ch.ready);
    slave_id_m = id;
    id_setting = id;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sender: holds an item until it is taken, with random gaps in between.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_ch.command   <= pending_items[0].command;
        req_ch.rx_byte   <= pending_items[0].rx_byte;
        req_ch.frame_end <= pending_items[0].frame_end;
        req_ch.reg_index <= pending_items[0].reg_index;
        req_ch.reg_value <= pending_items[0].reg_value;
        req_ch.valid     <= 1'b1;
        void'(pending_items.pop_front());
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Results are checked before the item taken at the same edge is predicted.
  always @(posedge clk_i) begin : scoreboard
    rsp_t want;
    req_t taken;
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result with nothing expected, tx_byte", 0, rsp_ch.tx_byte);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_ch.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", want.tx_valid, rsp_ch.tx_valid);
          if (rsp_ch.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", want.tx_byte, rsp_ch.tx_byte);
          if (rsp_ch.tx_last !== want.tx_last)
            report_mismatch("tx_last", want.tx_last, rsp_ch.tx_last);
          if (rsp_ch.frame_status !== want.frame_status)
            report_mismatch("frame_status", want.frame_status, rsp_ch.frame_status);
          n_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        taken.command   = req_ch.command;
        taken.rx_byte   = req_ch.rx_byte;
        taken.frame_end = req_ch.frame_end;
        taken.reg_index = req_ch.reg_index;
        taken.reg_value = req_ch.reg_value;
        predict_item(taken, want);
        expected_replies.push_back(want);
        n_taken++;
      end
      req_fire <= req_ch.valid && req_ch.ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_ids [5];
    req_t       it;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_RECV;
    req_ch.rx_byte   = 8'h00;
    req_ch.frame_end = 1'b0;
    req_ch.reg_index = 8'h00;
    req_ch.reg_value = 16'h0000;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.slave_id  = 8'h00;
    foreach (table_m[i]) table_m[i] = 16'h0000;
    clear_receiver();
    reply_armed = 1'b0;
    reply_pos   = 0;
    reply_start = 0;
    reply_qty   = 0;
    reply_crc_m = CRC_INIT;
    slave_id_m  = SLAVE_ID_RST;
    id_setting  = SLAVE_ID_RST;
    idle_en     = 1'b1;
    gap_left    = 0;
    stall_left  = 0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: empty pull, the unused command, table extremes and a read at the last entry.
    push_pulls(1);
    it = random_item();
    it.command = CMD_UNUSED;
    queue_item(it);
    push_write(8'h00, 16'hFFFF);
    push_write(8'hFF, 16'h8001);
    build_read(id_setting, FUNC_READ, 16'd255, 16'd1, 0);
    push_frame(1'b1, 1'b0);
    push_pulls(8);

    phase_ids = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), 8'($urandom_range(2, 254)),
                  SLAVE_ID_RST};
    for (int p = 0; p < 5; p++) begin
      // The sender stays quiet here until every result is in.
      wait_drained();
      write_slave_id(phase_ids[p]);
      if (p == 4) idle_en = 1'b0;
      @(posedge clk_i);
      if (p == 0) begin
        read_transaction(0, MAX_QUANTITY, 0);
        read_transaction(REG_DEPTH - MAX_QUANTITY, MAX_QUANTITY, 0);
        // Long frame so the byte count saturates.
        build_read(id_setting, FUNC_READ, 16'd10, 16'd3, 262);
        push_frame(1'b1, 1'b0);
        push_pulls(11);
      end
      while (pending_items.size() < PHASE_ITEMS) random_transaction();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("summary: %0d items over 6 slave address settings, %0d results checked",
             n_taken, n_checked);
    $display("summary: %0d frames accepted, %0d frames ignored, %0d mismatches",
             n_accepted, n_ignored, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mbus_rhr_pkg.sv
hdl/mbus_rhr_if.sv
hdl/mbus_rhr_regs.sv
hdl/mbus_rhr_rx.sv
hdl/mbus_rhr_tx.sv
hdl/modbus_read_holding_registers_slave_core.sv
dv/tb_modbus_read_holding_registers_slave_core.sv
